// ----- rtl/core/lwd_pkg.sv -----
package lwd_pkg;

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int BIAS_W      = 4;
    localparam int USER_W      = 2;
    localparam int MAX_RESULTS = 30;

    localparam logic [BIAS_W-1:0] BIAS_RESET = 4'd2;

    // default token geometry
    localparam int LITERAL_BITS_DEF      = 8;
    localparam int LENGTH_FIELD_BITS_DEF = 4;
    localparam int DISTANCE_BITS_DEF     = 12;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DECODE,
        ST_COPY,
        ST_FLUSH
    } dec_state_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              stream_end;
    } result_t;

    typedef struct packed
    {
        logic push;
        logic flush;
    } obuf_ctrl_t;

    typedef struct packed
    {
        logic can_push;
        logic flush_done;
    } obuf_sts_t;

endpackage

// ----- rtl/core/lwd_ram.sv -----
module lwd_ram
    import lwd_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = 2 ** DISTANCE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/lwd_out_buf.sv -----
module lwd_out_buf
    import lwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  obuf_ctrl_t        ctrl,
    input  result_t           res,
    output obuf_sts_t         sts,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res,
    output logic              out_last
);

    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg, pend_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;
    logic    out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;

        if (ctrl.push && (!pend_valid_reg || out_free))
        begin
            // older result is not the final one of its request
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = res;
            pend_valid_next = 1'b1;
        end
        else if (ctrl.flush && pend_valid_reg && out_free)
        begin
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign sts.can_push   = !pend_valid_reg || out_free;
    assign sts.flush_done = !pend_valid_reg || out_free;
    assign out_valid      = out_valid_reg;
    assign out_res        = out_reg;
    assign out_last       = out_last_reg;

endmodule

// ----- rtl/core/lwd_ctrl.sv -----
module lwd_ctrl
    import lwd_pkg::*;
#(
    parameter int LITERAL_BITS      = LITERAL_BITS_DEF,
    parameter int LENGTH_FIELD_BITS = LENGTH_FIELD_BITS_DEF,
    parameter int DISTANCE_BITS     = DISTANCE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [BYTE_W-1:0]        in_byte,
    input  logic [BIAS_W-1:0]        length_bias,
    output obuf_ctrl_t               obuf_ctrl,
    output result_t                  obuf_res,
    input  obuf_sts_t                obuf_sts,
    output logic                     ram_we,
    output logic [DISTANCE_BITS-1:0] ram_waddr,
    output logic [BYTE_W-1:0]        ram_wdata,
    output logic                     ram_re,
    output logic [DISTANCE_BITS-1:0] ram_raddr,
    input  logic [BYTE_W-1:0]        ram_rdata
);

    localparam int AW        = DISTANCE_BITS;
    localparam int TOK_LIT   = 1 + LITERAL_BITS;
    localparam int TOK_LEN   = 1 + LENGTH_FIELD_BITS;
    localparam int TOK_MATCH = TOK_LEN + DISTANCE_BITS;
    localparam int TOKEN_MAX = (TOK_LIT > TOK_MATCH) ? TOK_LIT : TOK_MATCH;
    localparam int HOLDER_W  = TOKEN_MAX + BYTE_W - 1;
    localparam int CNT_W     = $clog2(HOLDER_W + 1);
    localparam int RES_W     = $clog2(MAX_RESULTS + 1);
    localparam int LEN_MAX   = (1 << BIAS_W) + (1 << LENGTH_FIELD_BITS);
    localparam int SUM_MAX   = (LEN_MAX > 2 * MAX_RESULTS) ? LEN_MAX : 2 * MAX_RESULTS;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);

    dec_state_t            state_reg, state_next;
    logic                  phase_reg, phase_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [HOLDER_W-1:0]   holder_reg, holder_next;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic [RES_W-1:0]      n_reg, n_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [AW-1:0]         src_reg, src_next;
    logic [RES_W-1:0]      issue_cnt_reg, issue_cnt_next;
    logic [RES_W-1:0]      push_cnt_reg, push_cnt_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  stash_valid_reg, stash_valid_next;
    logic [BYTE_W-1:0]     stash_reg, stash_next;
    logic                  fwd_reg, fwd_next;
    logic [BYTE_W-1:0]     fwd_data_reg, fwd_data_next;

    logic                         flag;
    logic [LENGTH_FIELD_BITS-1:0] len_f;
    logic [LITERAL_BITS-1:0]      lit_f;
    logic [DISTANCE_BITS-1:0]     dist_f;
    logic                         end_code;
    logic [SUM_W-1:0]             n_ext;
    logic [SUM_W-1:0]             cnt_raw;
    logic [SUM_W-1:0]             cnt_cut;
    logic                         lit_ok;
    logic                         end_ok;
    logic                         match_ok;
    logic [BYTE_W-1:0]            rd_byte;
    logic                         have_data;
    logic [BYTE_W-1:0]            copy_byte;
    logic                         do_push;

    // token fields, least significant bit first
    assign flag     = holder_reg[0];
    assign len_f    = holder_reg[LENGTH_FIELD_BITS:1];
    assign lit_f    = holder_reg[LITERAL_BITS:1];
    assign dist_f   = holder_reg[TOK_MATCH-1:TOK_LEN];
    assign end_code = &len_f;
    assign n_ext    = SUM_W'(n_reg);
    assign cnt_raw  = SUM_W'(length_bias) + SUM_W'(1) + SUM_W'(len_f);
    assign cnt_cut  = (cnt_raw > SUM_W'(MAX_RESULTS)) ? SUM_W'(MAX_RESULTS) : cnt_raw;

    assign lit_ok   = !flag && (held_reg >= CNT_W'(TOK_LIT))
                      && (n_ext + SUM_W'(1) <= SUM_W'(MAX_RESULTS));
    assign end_ok   = flag && (held_reg >= CNT_W'(TOK_LEN)) && end_code
                      && (n_ext + SUM_W'(1) <= SUM_W'(MAX_RESULTS));
    assign match_ok = flag && (held_reg >= CNT_W'(TOK_LEN)) && !end_code
                      && (held_reg >= CNT_W'(TOK_MATCH))
                      && (n_ext + cnt_cut <= SUM_W'(MAX_RESULTS));

    // same-cycle write to the entry being read wins
    assign rd_byte   = fwd_reg ? fwd_data_reg : ram_rdata;
    assign have_data = stash_valid_reg || rd_valid_reg;
    assign copy_byte = stash_valid_reg ? stash_reg : rd_byte;
    assign do_push   = have_data && obuf_sts.can_push;

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        byte_next        = byte_reg;
        holder_next      = holder_reg;
        held_next        = held_reg;
        n_next           = n_reg;
        wp_next          = wp_reg;
        src_next         = src_reg;
        issue_cnt_next   = issue_cnt_reg;
        push_cnt_next    = push_cnt_reg;
        stash_valid_next = stash_valid_reg;
        stash_next       = stash_reg;

        in_ready             = 1'b0;
        obuf_ctrl.push       = 1'b0;
        obuf_ctrl.flush      = 1'b0;
        obuf_res.out_byte    = BYTE_W'(lit_f);
        obuf_res.byte_valid  = 1'b1;
        obuf_res.stream_end  = 1'b0;
        ram_we               = 1'b0;
        ram_waddr            = wp_reg;
        ram_wdata            = BYTE_W'(lit_f);
        ram_re               = 1'b0;
        ram_raddr            = src_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    byte_next  = in_byte;
                    phase_next = 1'b0;
                    n_next     = '0;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                priority if (lit_ok)
                begin
                    if (obuf_sts.can_push)
                    begin
                        obuf_ctrl.push = 1'b1;
                        ram_we         = 1'b1;
                        wp_next        = wp_reg + AW'(1);
                        n_next         = n_reg + RES_W'(1);
                        holder_next    = holder_reg >> TOK_LIT;
                        held_next      = held_reg - CNT_W'(TOK_LIT);
                    end
                end
                else if (end_ok)
                begin
                    if (obuf_sts.can_push)
                    begin
                        obuf_ctrl.push      = 1'b1;
                        obuf_res.out_byte   = '0;
                        obuf_res.byte_valid = 1'b0;
                        obuf_res.stream_end = 1'b1;
                        holder_next         = '0;
                        held_next           = '0;
                        wp_next             = '0;
                        n_next              = n_reg + RES_W'(1);
                    end
                end
                else if (match_ok)
                begin
                    src_next       = wp_reg - AW'(dist_f);
                    issue_cnt_next = cnt_cut[RES_W-1:0];
                    push_cnt_next  = cnt_cut[RES_W-1:0];
                    n_next         = RES_W'(n_ext + cnt_cut);
                    holder_next    = holder_reg >> TOK_MATCH;
                    held_next      = held_reg - CNT_W'(TOK_MATCH);
                    state_next     = ST_COPY;
                end
                else if (!phase_reg)
                begin
                    // held tokens done, take in the new byte above them
                    holder_next = holder_reg | (HOLDER_W'(byte_reg) << held_reg);
                    held_next   = held_reg + CNT_W'(BYTE_W);
                    phase_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_COPY:
            begin
                obuf_res.out_byte = copy_byte;
                ram_wdata         = copy_byte;
                if (do_push)
                begin
                    obuf_ctrl.push   = 1'b1;
                    ram_we           = 1'b1;
                    wp_next          = wp_reg + AW'(1);
                    push_cnt_next    = push_cnt_reg - RES_W'(1);
                    stash_valid_next = 1'b0;
                    if (push_cnt_reg == RES_W'(1))
                    begin
                        state_next = ST_DECODE;
                    end
                end
                else if (rd_valid_reg)
                begin
                    stash_next       = rd_byte;
                    stash_valid_next = 1'b1;
                end

                if ((issue_cnt_reg != '0) && !stash_valid_reg
                    && (!rd_valid_reg || obuf_sts.can_push))
                begin
                    ram_re         = 1'b1;
                    src_next       = src_reg + AW'(1);
                    issue_cnt_next = issue_cnt_reg - RES_W'(1);
                end
            end

            ST_FLUSH:
            begin
                obuf_ctrl.flush = 1'b1;
                if (obuf_sts.flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_valid_next = ram_re;
    assign fwd_next      = ram_re && ram_we && (ram_raddr == ram_waddr);
    assign fwd_data_next = ram_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 1'b0;
            holder_reg      <= '0;
            held_reg        <= '0;
            n_reg           <= '0;
            wp_reg          <= '0;
            issue_cnt_reg   <= '0;
            push_cnt_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            stash_valid_reg <= 1'b0;
            fwd_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            holder_reg      <= holder_next;
            held_reg        <= held_next;
            n_reg           <= n_next;
            wp_reg          <= wp_next;
            issue_cnt_reg   <= issue_cnt_next;
            push_cnt_reg    <= push_cnt_next;
            rd_valid_reg    <= rd_valid_next;
            stash_valid_reg <= stash_valid_next;
            fwd_reg         <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        src_reg      <= src_next;
        stash_reg    <= stash_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

// ----- rtl/core/lzss_window_decompress.sv -----
// LZSS stream decoder. Compressed bytes arrive one request at a time on the
// s_axis side; bits are taken least significant first. A token with flag 0
// carries a literal, written to the circular history window and sent out; a
// token with flag 1 carries a length field and a distance, and the block copies
// length_bias + 1 + length bytes from that far back in the window, sending each
// one. A length field of all ones is the end marker: one result with
// byte_valid low and stream_end high, the remaining held bits dropped and the
// window write position set back to zero (window contents kept). Each input
// byte gives zero to 30 results; the last of them carries tlast. Tokens whose
// results would exceed 30 for one byte are held and decoded first on the next.
// Each input byte passes through accept, append, a final decode check and
// flush, with one decode step per token; a match token also waits on the
// window read, as the window is a single synchronous RAM with one read and
// one write port. Results leave at one per cycle while the output is not
// back-pressured. The next byte is taken once the final result of the
// current one has moved into the output register. length_bias may only be
// changed while no byte is in progress; it resets to 2.
module lzss_window_decompress
    import lwd_pkg::*;
#(
    parameter int LITERAL_BITS      = LITERAL_BITS_DEF,
    parameter int LENGTH_FIELD_BITS = LENGTH_FIELD_BITS_DEF,
    parameter int DISTANCE_BITS     = DISTANCE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // length_bias register write
    input  logic              cfg_we,
    input  logic [BIAS_W-1:0] cfg_wdata,
    // compressed input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // code_byte
    // decoded output
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // out_byte
    output logic              m_axis_tlast,   // last result of the input request
    output logic [USER_W-1:0] m_axis_tuser    // byte_valid, stream_end
);

    logic [BIAS_W-1:0]        length_bias_reg;
    obuf_ctrl_t               obuf_ctrl;
    obuf_sts_t                obuf_sts;
    result_t                  obuf_res;
    result_t                  out_res;
    logic                     ram_we;
    logic [DISTANCE_BITS-1:0] ram_waddr;
    logic [BYTE_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [DISTANCE_BITS-1:0] ram_raddr;
    logic [BYTE_W-1:0]        ram_rdata;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_bias_reg <= BIAS_RESET;
        end
        else if (cfg_we)
        begin
            length_bias_reg <= cfg_wdata;
        end
    end

    // token decoder and copy sequencer
    lwd_ctrl #(
        .LITERAL_BITS      (LITERAL_BITS),
        .LENGTH_FIELD_BITS (LENGTH_FIELD_BITS),
        .DISTANCE_BITS     (DISTANCE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .length_bias (length_bias_reg),
        .obuf_ctrl   (obuf_ctrl),
        .obuf_res    (obuf_res),
        .obuf_sts    (obuf_sts),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // history window, never cleared
    lwd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (2 ** DISTANCE_BITS)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one result held back until it is known whether it is the last
    lwd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (obuf_ctrl),
        .res       (obuf_res),
        .sts       (obuf_sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_res.out_byte;
    assign m_axis_tuser = {out_res.stream_end, out_res.byte_valid};

endmodule
